// File: design/mp3s2_pkg.sv
// shared constants, register codes and helpers for the 3x3 stride-2 max pooling block
package mp3s2_pkg;

   // default sizing of the top level
   localparam int DEF_MAX_IN_WIDTH = 32;
   localparam int DEF_MAX_CHANNELS = 64;
   localparam int DEF_MAX_OUT_ROWS = 16;
   localparam int DEF_DATA_WIDTH   = 16;

   // fixed field widths
   localparam int OUT_ROWS_W = 5;
   localparam int OUT_COLS_W = 5;
   localparam int CHANNELS_W = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam int OUT_ROW_W = 4;
   localparam int OUT_COL_W = 4;
   localparam int CHANNEL_W = 6;

   // register values after reset, before range limiting
   localparam int RST_OUT_ROWS = 12;
   localparam int RST_OUT_COLS = 12;
   localparam int RST_CHANNELS = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OUT_ROWS = 2'd0,
      CSR_OUT_COLS = 2'd1,
      CSR_CHANNELS = 2'd2
   } csr_index_type;

   // limit a register value to 1..hi
   function automatic int clamp_cfg(input int value, input int hi);
      int res;
      res = value;
      if (res < 1) res = 1;
      if (res > hi) res = hi;
      return res;
   endfunction

endpackage

// File: design/mp3s2_ram.sv
// simple dual-port ram with registered read, one write and one read per cycle
module mp3s2_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/max_pool_3x3_stride2_top.sv
// top level of the streaming 3x3 stride-2 max pooling block
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_sample
//   rsp     | out       | rsp_valid / rsp_stall  | pooled_value, out_row, out_col, channel,
//           |           |                        | frame_end
//   csr     | in        | csr_write_en           | csr_index, csr_write_data
//
// one beat per cycle sustained unless rsp_stall holds the middle stage; the ram read and the
// middle stage load on the accepting edge, and the result register as that stage advances.
// the line store and the horizontal maxima are written as a beat leaves the middle stage;
// back-to-back hits on one horizontal entry are bypassed.
// reset is synchronous and clears the stream position and the registers to 12, 12, 64;
// the stores come up undefined and are written before their contents are used in every frame.
// req_stall rises in the same cycle as rsp_stall only while the middle stage holds a result.
module max_pool_3x3_stride2_top
   import mp3s2_pkg::*;
#(
   parameter int MAX_IN_WIDTH = DEF_MAX_IN_WIDTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_OUT_ROWS = DEF_MAX_OUT_ROWS,
   parameter int DATA_WIDTH   = DEF_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_pooled_value,
   output logic [OUT_ROW_W-1:0]         rsp_out_row,
   output logic [OUT_COL_W-1:0]         rsp_out_col,
   output logic [CHANNEL_W-1:0]         rsp_channel,
   output logic                         rsp_frame_end,
   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   localparam int RW  = $clog2(2 * MAX_OUT_ROWS);
   localparam int CW  = $clog2(MAX_IN_WIDTH);
   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int STORE_DEPTH = MAX_IN_WIDTH * MAX_CHANNELS;
   localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int RST_ROWS_C = clamp_cfg(RST_OUT_ROWS, MAX_OUT_ROWS);
   localparam int RST_COLS_C = clamp_cfg(RST_OUT_COLS, MAX_IN_WIDTH / 2);
   localparam int RST_CHAN_C = clamp_cfg(RST_CHANNELS, MAX_CHANNELS);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   // one sample in flight between the ram read and the result register
   typedef struct packed {
      data_type                 sample;
      logic [SAW-1:0]           store_addr;
      logic [CHW-1:0]           chan;
      logic                     even_row;
      logic                     even_emit;
      logic                     last_row;
      logic                     first_col;
      logic                     odd_col;
      logic                     last_col;
      logic [OUT_ROW_W-1:0]     orow;
      logic [OUT_COL_W-1:0]     ocol;
      logic                     fend;
   } stage_type;

   function automatic data_type smax(input data_type a, input data_type b);
      return (a > b) ? a : b;
   endfunction

   // configuration and stream position
   logic [OUT_ROWS_W-1:0] out_rows_ff, out_rows_in;
   logic [OUT_COLS_W-1:0] out_cols_ff, out_cols_in;
   logic [CHANNELS_W-1:0] channels_ff, channels_in;
   logic [RW-1:0]         row_cnt_ff, row_cnt_in;
   logic [CW-1:0]         col_cnt_ff, col_cnt_in;
   logic [CHW-1:0]        chan_cnt_ff, chan_cnt_in;

   // pipeline
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      fwd_ff, fwd_in;
   data_type  fwd_data_ff, fwd_data_in;
   logic      rsp_valid_ff, rsp_valid_in;
   data_type  rsp_value_ff, rsp_value_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CHANNEL_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic                 rsp_fend_ff, rsp_fend_in;

   logic     accept;
   logic     s1_adv;
   logic     s1_emit;
   logic     row_emits;
   logic     cfg_hit;
   logic     last_row_now;
   logic     last_col_now;
   logic     last_chan_now;
   logic     col_we;
   logic     rr_we;
   data_type col_wr_data;
   data_type rr_wr_data;
   data_type col_rd_data;
   data_type rr_rd_data;
   data_type hprev;
   data_type vx;
   data_type vert;
   data_type hv;
   data_type result;
   logic [SAW-1:0] store_rd_addr;

   // handshake
   always_comb begin
      s1_adv    = s1_valid_ff && (!s1_emit || !rsp_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !s1_adv;
      accept    = req_valid && !req_stall;
   end

   // position decode of the incoming beat
   always_comb begin
      last_row_now  = (int'(row_cnt_ff) + 1 == 2 * int'(out_rows_ff));
      last_col_now  = (int'(col_cnt_ff) + 1 == 2 * int'(out_cols_ff));
      last_chan_now = (int'(chan_cnt_ff) + 1 >= int'(channels_ff));
      store_rd_addr = SAW'(col_cnt_ff) * SAW'(MAX_CHANNELS) + SAW'(chan_cnt_ff);

      s1_in.sample     = req_sample;
      s1_in.store_addr = store_rd_addr;
      s1_in.chan       = chan_cnt_ff;
      s1_in.even_row   = !row_cnt_ff[0];
      s1_in.even_emit  = !row_cnt_ff[0] && (int'(row_cnt_ff) >= 2);
      s1_in.last_row   = last_row_now;
      s1_in.first_col  = (col_cnt_ff == '0);
      s1_in.odd_col    = col_cnt_ff[0];
      s1_in.last_col   = last_col_now;
      s1_in.orow       = last_row_now ? OUT_ROW_W'(out_rows_ff - OUT_ROWS_W'(1))
                                      : OUT_ROW_W'((row_cnt_ff >> 1) - RW'(1));
      s1_in.ocol       = last_col_now ? OUT_COL_W'(out_cols_ff - OUT_COLS_W'(1))
                                      : OUT_COL_W'((col_cnt_ff >> 1) - CW'(1));
      s1_in.fend       = last_row_now && last_col_now && last_chan_now;
   end

   // stream position and configuration registers
   always_comb begin
      out_rows_in = out_rows_ff;
      out_cols_in = out_cols_ff;
      channels_in = channels_ff;
      row_cnt_in  = row_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      chan_cnt_in = chan_cnt_ff;
      cfg_hit     = 1'b0;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_OUT_ROWS: begin
               out_rows_in = OUT_ROWS_W'(clamp_cfg(int'(csr_write_data[OUT_ROWS_W-1:0]),
                                                   MAX_OUT_ROWS));
               cfg_hit     = 1'b1;
            end
            CSR_OUT_COLS: begin
               out_cols_in = OUT_COLS_W'(clamp_cfg(int'(csr_write_data[OUT_COLS_W-1:0]),
                                                   MAX_IN_WIDTH / 2));
               cfg_hit     = 1'b1;
            end
            CSR_CHANNELS: begin
               channels_in = CHANNELS_W'(clamp_cfg(int'(csr_write_data), MAX_CHANNELS));
               cfg_hit     = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
      if (cfg_hit) begin
         row_cnt_in  = '0;
         col_cnt_in  = '0;
         chan_cnt_in = '0;
      end else if (accept) begin
         if (last_chan_now) begin
            chan_cnt_in = '0;
            if (last_col_now) begin
               col_cnt_in = '0;
               row_cnt_in = last_row_now ? '0 : row_cnt_ff + RW'(1);
            end else begin
               col_cnt_in = col_cnt_ff + CW'(1);
            end
         end else begin
            chan_cnt_in = chan_cnt_ff + CHW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_rows_ff <= OUT_ROWS_W'(RST_ROWS_C);
         out_cols_ff <= OUT_COLS_W'(RST_COLS_C);
         channels_ff <= CHANNELS_W'(RST_CHAN_C);
         row_cnt_ff  <= '0;
         col_cnt_ff  <= '0;
         chan_cnt_ff <= '0;
      end else begin
         out_rows_ff <= out_rows_in;
         out_cols_ff <= out_cols_in;
         channels_ff <= channels_in;
         row_cnt_ff  <= row_cnt_in;
         col_cnt_ff  <= col_cnt_in;
         chan_cnt_ff <= chan_cnt_in;
      end
   end

   // vertical and horizontal maxima for the beat in the middle stage
   always_comb begin
      hprev     = fwd_ff ? fwd_data_ff : rr_rd_data;
      vx        = smax(col_rd_data, s1_ff.sample);
      row_emits = s1_ff.even_emit || s1_ff.last_row;
      if (s1_ff.even_emit) begin
         vert = vx;
      end else if (s1_ff.last_row) begin
         vert = smax(vx, '0);
      end else begin
         vert = '0;
      end
      hv          = smax(hprev, vert);
      result      = s1_ff.last_col ? smax(hv, '0) : hv;
      s1_emit     = row_emits && !s1_ff.first_col && (s1_ff.last_col || !s1_ff.odd_col);
      col_wr_data = s1_ff.even_row ? s1_ff.sample : vx;
      col_we      = s1_adv;
      rr_wr_data  = (s1_ff.odd_col && !s1_ff.first_col) ? hv : vert;
      rr_we       = s1_adv && row_emits && !s1_ff.last_col;
   end

   // bypass a horizontal entry written in the same cycle it is read
   always_comb begin
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         fwd_in      = rr_we && (s1_ff.chan == chan_cnt_ff);
         fwd_data_in = rr_wr_data;
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      fwd_data_ff <= fwd_data_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_fend_in  = rsp_fend_ff;
      if (s1_adv && s1_emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result;
         rsp_row_in   = s1_ff.orow;
         rsp_col_in   = s1_ff.ocol;
         rsp_chan_in  = CHANNEL_W'(s1_ff.chan);
         rsp_fend_in  = s1_ff.fend;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_fend_ff  <= rsp_fend_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_channel      = rsp_chan_ff;
   assign rsp_frame_end    = rsp_fend_ff;

   // line store of vertical maxima, one entry per column and channel
   mp3s2_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (DATA_WIDTH),
      .AW    (SAW)
   ) u_col_store (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (s1_ff.store_addr),
      .wr_data (col_wr_data),
      .rd_en   (accept),
      .rd_addr (store_rd_addr),
      .rd_data (col_rd_data)
   );

   // running horizontal maximum per channel
   mp3s2_ram #(
      .DEPTH (MAX_CHANNELS),
      .WIDTH (DATA_WIDTH),
      .AW    (CHW)
   ) u_row_max (
      .clock   (clock),
      .wr_en   (rr_we),
      .wr_addr (s1_ff.chan),
      .wr_data (rr_wr_data),
      .rd_en   (accept),
      .rd_addr (chan_cnt_ff),
      .rd_data (rr_rd_data)
   );

`ifndef NO_ASSERTIONS
   // input side only holds off while the middle stage is blocked
   a_stall_needs_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_emit && rsp_valid_ff && rsp_stall)
      else $error("req_stall without a blocked middle stage");

   // channel position stays below the configured count
   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(chan_cnt_ff) < int'(channels_ff))
      else $error("channel counter out of range");

   // same-entry bypass only arises with a single channel
   a_fwd_single_chan: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && fwd_ff |-> channels_ff == CHANNELS_W'(1))
      else $error("horizontal bypass with more than one channel");

   // end of map lands on the last output column and row
   a_fend_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fend_ff |->
         rsp_col_ff == OUT_COL_W'(out_cols_ff - OUT_COLS_W'(1)) &&
         rsp_row_ff == OUT_ROW_W'(out_rows_ff - OUT_ROWS_W'(1)))
      else $error("frame end away from the last window");

   // a middle-stage beat that leaves with a result always fills the result register
   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_emit |=> rsp_valid_ff)
      else $error("emitted beat lost");
`endif

endmodule
